// File: hw/rtl/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

  localparam longint MAX_TEXT = 64'd65536;
  localparam logic [15:0] POS_CAP = 16'((MAX_TEXT - 1 < 65535) ? MAX_TEXT - 1 : 65535);

  localparam int QUEUE_DEPTH = 4;
  localparam int NKW = 16;

  localparam logic [4:0] K_INVALID = 5'd0;
  localparam logic [4:0] K_EOF     = 5'd1;
  localparam logic [4:0] K_COLON   = 5'd2;
  localparam logic [4:0] K_KW0     = 5'd3;
  localparam logic [4:0] K_KWLAST  = 5'd18;
  localparam logic [4:0] K_ID      = 5'd19;
  localparam logic [4:0] K_NUM     = 5'd20;

  localparam logic [7:0] KW_CH0 [NKW] = '{
    "j", "l", "n", "a", "s", "m", "d", "g", "l", "s", "g", "m", "j", "j", "i", "d"
  };
  localparam logic [7:0] KW_CH1 [NKW] = '{
    "m", "o", "o", "d", "u", "u", "i", "t", "t", "e", "e", "o", "e", "n", "n", "b"
  };
  localparam logic [7:0] KW_CH2 [NKW] = '{
    "p", "a", "p", "d", "b", "l", "v", 8'h00, 8'h00, "t", "t", "v", "q", "e", "t", 8'h00
  };
  localparam logic [7:0] KW_CH3 [NKW] = '{
    8'h00, "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } ats_tok_t;

  typedef struct packed {
    logic     two;
    ats_tok_t tok0;
    ats_tok_t tok1;
  } ats_pair_t;

  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [1:0] depth);
    logic [7:0] ch;
    case (depth)
      2'd1:    ch = KW_CH1[idx];
      2'd2:    ch = KW_CH2[idx];
      2'd3:    ch = KW_CH3[idx];
      default: ch = KW_CH0[idx];
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/assembly_token_scanner_unit.sv
`timescale 1ns / 1ps
// A character's first token is written into the pair queue at the edge that accepts it,
// and is then loaded from the queue head into the output register.
// Throughput: one character per cycle unless the queue is full; a character that closes a
// token and opens another yields two tokens; the scanner-to-output pair queue absorbs them.
// Reset (synchronous, active low) returns the scanner to a token start at offset zero
// and empties the queue and the output register.

module assembly_token_scanner_unit #(
  parameter int Q_DEPTH = ats_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);
  import ats_pkg::*;

  logic push, pop, q_valid, q_full;
  ats_pair_t push_pair, head_pair;

  ats_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .pair     (push_pair)
  );

  ats_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (push_pair),
    .pop     (pop),
    .dout    (head_pair),
    .q_valid (q_valid),
    .full    (q_full)
  );

  ats_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (head_pair),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// File: hw/rtl/ats_front.sv
`timescale 1ns / 1ps

module ats_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_ch,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output ats_pkg::ats_pair_t pair
);
  import ats_pkg::*;

  typedef enum logic [5:0] {
    S_START  = 6'b000001,
    S_KEY    = 6'b000010,
    S_IDENT  = 6'b000100,
    S_MINUS  = 6'b001000,
    S_NUMBER = 6'b010000,
    S_HOLD   = 6'b100000
  } scan_state_t;

  scan_state_t state_r, state_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] begin_r, begin_nxt;
  logic [NKW-1:0] mask_r, mask_nxt;
  logic [1:0] depth_r, depth_nxt;

  logic accept;
  logic is_zero, is_space, is_letter, is_digit, is_idchar, is_colon, is_minus;
  logic [NKW-1:0] m0, mk;
  logic done;
  logic [3:0] done_idx;

  logic ts_emit, ts_end, ts_set_begin;
  ats_tok_t ts_tok;
  scan_state_t ts_state;

  logic emit_a, emit_b, use_ts, text_end;
  ats_tok_t tok_a, tok_b;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  assign is_zero   = (in_ch == 8'h00);
  assign is_space  = in_ch inside {8'h20, [8'h09:8'h0D]};
  assign is_letter = in_ch inside {["a":"z"], ["A":"Z"]};
  assign is_digit  = in_ch inside {["0":"9"]};
  assign is_idchar = is_letter || is_digit || (in_ch == "_");
  assign is_colon  = (in_ch == ":");
  assign is_minus  = (in_ch == "-");

  always_comb begin
    done = 1'b0;
    done_idx = '0;
    for (int i = 0; i < NKW; i++) begin
      m0[i] = (KW_CH0[i] == in_ch);
      mk[i] = mask_r[i] && (KW_LEN[i] > 3'(depth_r)) && (kw_char(4'(i), depth_r) == in_ch);
    end
    for (int i = NKW - 1; i >= 0; i--) begin
      if (mk[i] && (KW_LEN[i] == 3'(depth_r) + 3'd1)) begin
        done = 1'b1;
        done_idx = 4'(i);
      end
    end
  end

  always_comb begin
    ts_emit = 1'b0;
    ts_end = 1'b0;
    ts_set_begin = 1'b0;
    ts_state = S_START;
    ts_tok = '{kind: K_INVALID, start: pos_r, length: 16'd0};
    if (is_zero) begin
      ts_emit = 1'b1;
      ts_end = 1'b1;
      ts_tok.kind = K_EOF;
    end else if (is_space) begin
      ts_state = S_START;
    end else if (is_colon) begin
      ts_emit = 1'b1;
      ts_set_begin = 1'b1;
      ts_tok.kind = K_COLON;
      ts_tok.length = 16'd1;
    end else if (is_letter) begin
      ts_set_begin = 1'b1;
      ts_state = (|m0) ? S_KEY : S_IDENT;
    end else if (is_digit) begin
      ts_set_begin = 1'b1;
      ts_state = S_NUMBER;
    end else if (is_minus) begin
      ts_set_begin = 1'b1;
      ts_state = S_MINUS;
    end else begin
      ts_emit = 1'b1;
      ts_set_begin = 1'b1;
      ts_state = S_HOLD;
    end
  end

  always_comb begin
    state_nxt = S_START;
    mask_nxt = mask_r;
    depth_nxt = depth_r;
    begin_nxt = begin_r;
    emit_a = 1'b0;
    emit_b = 1'b0;
    use_ts = 1'b0;
    text_end = 1'b0;
    tok_a = '{kind: K_INVALID, start: begin_r, length: 16'd0};
    tok_b = '{kind: K_EOF, start: pos_r, length: 16'd0};
    case (state_r)
      S_HOLD: begin
        state_nxt = S_HOLD;
        if (is_zero) begin
          emit_a = 1'b1;
          tok_a = '{kind: K_EOF, start: pos_r, length: 16'd0};
          text_end = 1'b1;
          state_nxt = S_START;
        end
      end
      S_KEY: begin
        if (|mk) begin
          if (done) begin
            emit_a = 1'b1;
            tok_a = '{kind: K_KW0 + 5'(done_idx), start: begin_r,
                      length: 16'(KW_LEN[done_idx])};
          end else begin
            mask_nxt = mk;
            depth_nxt = depth_r + 2'd1;
            state_nxt = S_KEY;
          end
        end else if (is_idchar) begin
          state_nxt = S_IDENT;
        end else begin
          emit_a = 1'b1;
          tok_a = '{kind: K_ID, start: begin_r, length: pos_r - begin_r};
          use_ts = 1'b1;
        end
      end
      S_IDENT: begin
        if (is_idchar) begin
          state_nxt = S_IDENT;
        end else begin
          emit_a = 1'b1;
          tok_a = '{kind: K_ID, start: begin_r, length: pos_r - begin_r};
          use_ts = 1'b1;
        end
      end
      S_NUMBER: begin
        if (is_digit) begin
          state_nxt = S_NUMBER;
        end else begin
          emit_a = 1'b1;
          tok_a = '{kind: K_NUM, start: begin_r, length: pos_r - begin_r};
          use_ts = 1'b1;
        end
      end
      S_MINUS: begin
        if (is_digit) begin
          state_nxt = S_NUMBER;
        end else begin
          emit_a = 1'b1;
          if (is_zero) begin
            emit_b = 1'b1;
            text_end = 1'b1;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      default: begin
        use_ts = 1'b1;
      end
    endcase

    if (use_ts) begin
      state_nxt = ts_state;
      text_end = ts_end;
      if (ts_set_begin) begin
        begin_nxt = pos_r;
      end
      if (ts_state == S_KEY || ts_state == S_IDENT) begin
        mask_nxt = m0;
        depth_nxt = 2'd1;
      end
      if (emit_a) begin
        emit_b = ts_emit;
        tok_b = ts_tok;
      end else begin
        emit_a = ts_emit;
        tok_a = ts_tok;
      end
    end

    if (text_end) begin
      begin_nxt = 16'd0;
      pos_nxt = 16'd0;
    end else if (pos_r == POS_CAP) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  assign push = accept && emit_a;
  assign pair = '{two: emit_b, tok0: tok_a, tok1: tok_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      pos_r <= 16'd0;
      begin_r <= 16'd0;
    end else if (accept) begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      begin_r <= begin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r <= mask_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

// File: hw/rtl/ats_queue.sv
`timescale 1ns / 1ps

module ats_queue #(
  parameter int DEPTH = ats_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ats_pkg::ats_pair_t din,
  input  logic               pop,
  output ats_pkg::ats_pair_t dout,
  output logic               q_valid,
  output logic               full
);
  import ats_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ats_pair_t entries_r [DEPTH];
  logic [PW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic do_pop;

  assign q_valid = (count_r != '0);
  assign full = (count_r == CW'(DEPTH));
  assign do_pop = pop && q_valid;
  assign dout = entries_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[tail_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == LAST) ? '0 : tail_r + PW'(1);
      end
      if (do_pop) begin
        head_r <= (head_r == LAST) ? '0 : head_r + PW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ats_back.sv
`timescale 1ns / 1ps

module ats_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ats_pkg::ats_pair_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_token_kind,
  output logic [15:0]        out_token_start,
  output logic [15:0]        out_token_length,
  output logic               out_last_of_run
);
  import ats_pkg::*;

  logic out_valid_r, sec_r, last_r;
  ats_tok_t tok_r, second_r;
  logic take, free;

  assign take = out_valid_r && !out_stall;
  assign free = !out_valid_r || (take && !sec_r);
  assign pop = free && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_r <= 1'b0;
    end else if (take && sec_r) begin
      sec_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      sec_r <= q_data.two;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && sec_r) begin
      tok_r <= second_r;
      last_r <= 1'b1;
    end else if (pop) begin
      tok_r <= q_data.tok0;
      last_r <= !q_data.two;
      second_r <= q_data.tok1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_token_kind = tok_r.kind;
  assign out_token_start = tok_r.start;
  assign out_token_length = tok_r.length;
  assign out_last_of_run = last_r;

endmodule

// File: hw/rtl/ats_checker.sv
`timescale 1ns / 1ps

module ats_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);
  import ats_pkg::*;

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) && $stable(out_last_of_run))
    else $error("stalled item changed");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_token_length == 16'd0 && out_last_of_run)
    else $error("end-of-text item malformed");

  a_colon_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_COLON |-> out_token_length == 16'd1)
    else $error("colon item length wrong");

  a_keyword_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind >= K_KW0 && out_token_kind <= K_KWLAST |->
      out_token_length >= 16'd2 && out_token_length <= 16'd4)
    else $error("keyword item length wrong");

endmodule

bind assembly_token_scanner_unit ats_checker u_ats_checker (.*);

// File: sim/assembly_token_scanner_unit_test.sv
`timescale 1ns / 1ps

module assembly_token_scanner_unit_test;
  import ats_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS = 100;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_KEYWORD,
    SCAN_IDENT,
    SCAN_MINUS,
    SCAN_NUMBER
  } scan_phase_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } scan_token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  scan_token_t expected_tokens[$];
  scan_token_t step_tokens[$];

  string kw_words [16] = '{"jmp", "load", "nop", "add", "sub", "mul", "div", "gt",
                           "lt", "set", "get", "mov", "jeq", "jne", "int", "db"};

  scan_phase_t phase = SCAN_START;
  logic [15:0] pos_q = '0;
  logic [15:0] begin_q = '0;
  logic [15:0] kw_cand = '0;
  int          kw_depth = 0;
  bit          held = 1'b0;

  bit idle_enable = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int scanned_items = 0;
  int ignored_items = 0;

  assembly_token_scanner_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_idchar(logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "_";
  endfunction

  function automatic void emit_token(logic [4:0] kind, logic [15:0] start,
                                     logic [15:0] length);
    scan_token_t t;
    t.kind = kind;
    t.start = start;
    t.length = length;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void restart_text();
    phase = SCAN_START;
    pos_q = '0;
    begin_q = '0;
    held = 1'b0;
    kw_cand = '0;
    kw_depth = 0;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [15:0] pos);
    logic [15:0] m;
    int i;
    m = '0;
    if (c == 8'h00) begin
      emit_token(K_EOF, pos, 16'd0);
      restart_text();
    end else if (!is_space(c)) begin
      begin_q = pos;
      if (c == ":") begin
        emit_token(K_COLON, pos, 16'd1);
      end else if (is_letter(c)) begin
        for (i = 0; i < 16; i++) begin
          if (kw_words[i][0] == c) m[i] = 1'b1;
        end
        kw_cand = m;
        kw_depth = 1;
        phase = (m != 0) ? SCAN_KEYWORD : SCAN_IDENT;
      end else if (is_digit(c)) begin
        phase = SCAN_NUMBER;
      end else if (c == "-") begin
        phase = SCAN_MINUS;
      end else begin
        emit_token(K_INVALID, pos, 16'd0);
        held = 1'b1;
      end
    end
  endfunction

  function automatic void predict_char(logic [7:0] c);
    logic [15:0] pos;
    logic [15:0] m;
    scan_phase_t st;
    int i;
    bit done;
    pos = pos_q;
    m = '0;
    done = 1'b0;
    step_tokens.delete();
    if (held) begin
      if (c == 8'h00) begin
        emit_token(K_EOF, pos, 16'd0);
        restart_text();
      end
    end else begin
      st = phase;
      phase = SCAN_START;
      case (st)
        SCAN_KEYWORD: begin
          for (i = 0; i < 16; i++) begin
            if (kw_cand[i] && kw_depth < kw_words[i].len() && kw_words[i][kw_depth] == c)
              m[i] = 1'b1;
          end
          if (m != 0) begin
            for (i = 0; i < 16; i++) begin
              if (!done && m[i] && kw_words[i].len() == kw_depth + 1) begin
                emit_token(K_KW0 + 5'(i), begin_q, 16'(kw_words[i].len()));
                done = 1'b1;
              end
            end
            if (!done) begin
              kw_cand = m;
              kw_depth++;
              phase = SCAN_KEYWORD;
            end
          end else if (is_idchar(c)) begin
            phase = SCAN_IDENT;
          end else begin
            emit_token(K_ID, begin_q, pos - begin_q);
            open_token(c, pos);
          end
        end
        SCAN_IDENT: begin
          if (is_idchar(c)) begin
            phase = SCAN_IDENT;
          end else begin
            emit_token(K_ID, begin_q, pos - begin_q);
            open_token(c, pos);
          end
        end
        SCAN_NUMBER: begin
          if (is_digit(c)) begin
            phase = SCAN_NUMBER;
          end else begin
            emit_token(K_NUM, begin_q, pos - begin_q);
            open_token(c, pos);
          end
        end
        SCAN_MINUS: begin
          if (is_digit(c)) begin
            phase = SCAN_NUMBER;
          end else begin
            emit_token(K_INVALID, begin_q, 16'd0);
            if (c == 8'h00) begin
              emit_token(K_EOF, pos, 16'd0);
              restart_text();
            end else begin
              held = 1'b1;
            end
          end
        end
        default: open_token(c, pos);
      endcase
      if (st != SCAN_START && phase == SCAN_START && !held) kw_cand = '0;
    end
    if (!(c == 8'h00 && step_tokens.size() > 0 && step_tokens[$].kind == K_EOF)) begin
      if (pos_q < POS_CAP) pos_q = pos_q + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (held) ignored_items++;
    else scanned_items++;
    predict_char(c);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_idchar();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) send_char(8'("a" + r));
    else if (r < 52) send_char(8'("A" + r - 26));
    else if (r < 62) send_char(8'("0" + r - 52));
    else send_char("_");
  endtask

  task automatic send_random_text();
    int n;
    int t;
    int r;
    int k;
    int j;
    string w;
    n = $urandom_range(1, 12);
    for (t = 0; t < n; t++) begin
      r = $urandom_range(0, 29);
      if (r <= 8) begin
        send_text(kw_words[$urandom_range(0, 15)]);
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(1, 3);
          for (j = 0; j < k; j++) send_idchar();
        end
      end else if (r <= 11) begin
        w = kw_words[$urandom_range(0, 15)];
        send_text(w.substr(0, w.len() - 2));
        if ($urandom_range(0, 1) == 0) send_idchar();
      end else if (r <= 18) begin
        k = $urandom_range(0, 51);
        send_char(k < 26 ? 8'("a" + k) : 8'("A" + k - 26));
        k = $urandom_range(0, 7);
        for (j = 0; j < k; j++) send_idchar();
      end else if (r <= 24) begin
        if ($urandom_range(0, 2) == 0) send_char("-");
        k = $urandom_range(1, 5);
        for (j = 0; j < k; j++) send_char(8'("0" + $urandom_range(0, 9)));
      end else if (r <= 27) begin
        send_char(":");
      end else if (r == 28) begin
        send_char("-");
      end else begin
        send_char(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 3) != 0) begin
        k = $urandom_range(1, 2);
        for (j = 0; j < k; j++) begin
          r = $urandom_range(0, 5);
          send_char(r == 0 ? 8'd32 : 8'(8 + r));
        end
      end
    end
    send_char(8'h00);
  endtask

  task automatic test_directed();
    send_text("gt7 -42:\n");
    send_char(8'h00);
    send_text("- x");
    send_char(8'h00);
    send_char("-");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h00);
    send_text("Z_9");
    send_char(8'h00);
    send_char(8'h00);
  endtask

  task automatic test_output_backpressure();
    hold_requests++;
    send_text("a b c d e f g h 1:2:3:4:5: mov x\n");
    send_char(8'h00);
  endtask

  task automatic test_long_token();
    int i;
    send_char("x");
    for (i = 0; i < 60; i++) send_char("a");
    send_text(" dbq 5");
    send_char(8'h00);
  endtask

  task automatic test_random_text(input int item_target);
    int first;
    first = scanned_items;
    while (scanned_items - first < item_target) send_random_text();
  endtask

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    scan_token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d start %0d with nothing pending",
                                  out_token_kind, out_token_start));
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_token_kind, want.kind));
        if (out_token_start !== want.start)
          report_mismatch($sformatf("start %0d, expected %0d", out_token_start, want.start));
        if (out_token_length !== want.length)
          report_mismatch($sformatf("length %0d, expected %0d", out_token_length,
                                    want.length));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0d, expected %0d", out_last_of_run,
                                    want.last));
        tokens_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout with %0d tokens outstanding", expected_tokens.size());
      $display("assembly_token_scanner_unit_test: errors");
      $finish;
    end
  end

  initial begin
    restart_text();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_output_backpressure();
    wait_drain();
    test_long_token();
    wait_drain();
    test_random_text(800);
    idle_enable = 1'b0;
    test_random_text(200);
    wait_drain();
    $display("Scanned %0d characters (%0d ignored after errors), checked %0d tokens.",
             scanned_items, ignored_items, tokens_checked);
    $display("Included a long output hold-off and a 61-character identifier.");
    if (mismatches == 0) begin
      $display("assembly_token_scanner_unit_test: clean");
    end else begin
      $display("assembly_token_scanner_unit_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ats_pkg.sv
hw/rtl/ats_front.sv
hw/rtl/ats_queue.sv
hw/rtl/ats_back.sv
hw/rtl/assembly_token_scanner_unit.sv
hw/rtl/ats_checker.sv
sim/assembly_token_scanner_unit_test.sv
